[rtl/iats_pkg.sv]
package iats_pkg;

    localparam int unsigned STAT_W      = 16;
    localparam int unsigned SHARP_W     = 20;
    localparam int unsigned OUT_W       = 15;
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 20;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 128;
    localparam int unsigned RATE_W      = 7;

    // Q8.8 limits
    localparam logic [STAT_W-1:0] MIN_DIVISOR        = 16'd5120;
    localparam logic [STAT_W-1:0] CONTRAST_LOW_BAND  = 16'd11520;
    localparam logic [STAT_W-1:0] CONTRAST_HIGH_BAND = 16'd24320;

    localparam logic [OUT_W-1:0] OUT_MAX = 15'h7fff;

    localparam logic [STAT_W-1:0]  LUMA_GOAL_RST    = 16'd26880;
    localparam logic [STAT_W-1:0]  DARK_THR_RST     = 16'd14080;
    localparam logic [STAT_W-1:0]  BRIGHT_THR_RST   = 16'd42240;
    localparam logic [STAT_W-1:0]  NOISE_THR_RST    = 16'd2048;
    localparam logic [STAT_W-1:0]  LOW_CON_THR_RST  = 16'd10752;
    localparam logic [SHARP_W-1:0] SOFT_THR_RST     = 20'd700;

    typedef enum logic [2:0] {
        PROF_NORMAL       = 3'd0,
        PROF_LOW_LIGHT    = 3'd1,
        PROF_BRIGHT       = 3'd2,
        PROF_HIGH_NOISE   = 3'd3,
        PROF_LOW_CONTRAST = 3'd4,
        PROF_SOFT         = 3'd5
    } profile_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LUMA_GOAL    = 3'd0,
        CFG_DARK_THR     = 3'd1,
        CFG_BRIGHT_THR   = 3'd2,
        CFG_NOISE_THR    = 3'd3,
        CFG_LOW_CON_THR  = 3'd4,
        CFG_SOFT_THR     = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        LANE_GAIN    = 2'd0,
        LANE_GAMMA   = 2'd1,
        LANE_DENOISE = 2'd2,
        LANE_SHARPEN = 2'd3
    } lane_t;

    // decimal constant pct/100 in fixed point, halves rounded up
    function automatic longint unsigned fxc(input int unsigned pct, input int unsigned frac);
        return ((64'(pct) << frac) + 64'd50) / 64'd100;
    endfunction

    // smoothing rate in percent per lane
    function automatic logic [RATE_W-1:0] blend_rate(input lane_t lane);
        logic [RATE_W-1:0] r;
        case (lane)
            LANE_GAIN:  r = 7'd18;
            LANE_GAMMA: r = 7'd16;
            default:    r = 7'd22;
        endcase
        return r;
    endfunction

endpackage

[rtl/iats_div.sv]
module iats_div import iats_pkg::*; #(
    parameter int unsigned FRAC_BITS = 14
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [STAT_W-1:0]        target,
    input  logic [STAT_W-1:0]        divisor,
    output logic                     done,
    output logic [FRAC_BITS+3:0]     quotient
);

    // divisor >= 5120 keeps the quotient below 2^(FRAC_BITS+4), so the
    // top twelve bits of the target start as the partial remainder
    localparam int unsigned QW = FRAC_BITS + 4;
    localparam int unsigned CW = $clog2(QW + 1);

    logic [STAT_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]     quo_reg, quo_next;
    logic [STAT_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [STAT_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = {4'b0, target[STAT_W-1:4]};
            quo_next  = {target[3:0], {FRAC_BITS{1'b0}}};
            dvs_next  = divisor;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one quotient bit per cycle, shifted in where dividend bits leave
            rem_next = fits ? STAT_W'(trial - {1'b0, dvs_reg}) : trial[STAT_W-1:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/iats_select.sv]
module iats_select import iats_pkg::*; #(
    parameter int unsigned FRAC_BITS = 14
) (
    input  logic                 aclk,
    input  logic                 load,
    input  logic [STAT_W-1:0]    brightness,
    input  logic [STAT_W-1:0]    contrast_level,
    input  logic [STAT_W-1:0]    noise_level,
    input  logic [SHARP_W-1:0]   sharpness_level,
    input  logic [STAT_W-1:0]    dark_thr,
    input  logic [STAT_W-1:0]    bright_thr,
    input  logic [STAT_W-1:0]    noise_thr,
    input  logic [STAT_W-1:0]    low_con_thr,
    input  logic [SHARP_W-1:0]   soft_thr,
    output profile_t             profile,
    output logic [FRAC_BITS:0]   prop_gamma,
    output logic [FRAC_BITS:0]   prop_denoise,
    output logic [FRAC_BITS:0]   prop_sharpen,
    output logic [FRAC_BITS:0]   shadow,
    output logic [FRAC_BITS:0]   highlight,
    output logic [FRAC_BITS:0]   tone,
    output logic                 local_eq,
    output logic [FRAC_BITS:0]   contrast_factor
);

    localparam int unsigned SW = FRAC_BITS + 1;

    profile_t        prof;
    logic [SW-1:0]   gamma_c, denoise_c, sharpen_c, shadow_c, highlight_c, tone_c, cf_c;
    logic            leq_c;

    profile_t        profile_reg;
    logic [SW-1:0]   gamma_reg, denoise_reg, sharpen_reg, shadow_reg, highlight_reg;
    logic [SW-1:0]   tone_reg, cf_reg;
    logic            leq_reg;

    // first match wins
    always_comb begin
        if (brightness < dark_thr) begin
            prof = PROF_LOW_LIGHT;
        end else if (brightness > bright_thr) begin
            prof = PROF_BRIGHT;
        end else if (noise_level > noise_thr) begin
            prof = PROF_HIGH_NOISE;
        end else if (contrast_level < low_con_thr) begin
            prof = PROF_LOW_CONTRAST;
        end else if (sharpness_level < soft_thr) begin
            prof = PROF_SOFT;
        end else begin
            prof = PROF_NORMAL;
        end
    end

    always_comb begin
        case (prof)
            PROF_LOW_LIGHT: begin
                gamma_c     = SW'(fxc(72, FRAC_BITS));
                denoise_c   = SW'(fxc(45, FRAC_BITS));
                sharpen_c   = SW'(fxc(12, FRAC_BITS));
                shadow_c    = SW'(fxc(20, FRAC_BITS));
                highlight_c = SW'(fxc(12, FRAC_BITS));
                tone_c      = SW'(fxc(45, FRAC_BITS));
                leq_c       = 1'b1;
            end
            PROF_BRIGHT: begin
                gamma_c     = SW'(fxc(118, FRAC_BITS));
                denoise_c   = SW'(fxc(5, FRAC_BITS));
                sharpen_c   = SW'(fxc(8, FRAC_BITS));
                shadow_c    = SW'(fxc(2, FRAC_BITS));
                highlight_c = SW'(fxc(32, FRAC_BITS));
                tone_c      = SW'(fxc(42, FRAC_BITS));
                leq_c       = 1'b0;
            end
            PROF_HIGH_NOISE: begin
                gamma_c     = SW'(fxc(82, FRAC_BITS));
                denoise_c   = SW'(fxc(38, FRAC_BITS));
                sharpen_c   = SW'(fxc(14, FRAC_BITS));
                shadow_c    = SW'(fxc(8, FRAC_BITS));
                highlight_c = SW'(fxc(15, FRAC_BITS));
                tone_c      = SW'(fxc(34, FRAC_BITS));
                leq_c       = 1'b0;
            end
            PROF_LOW_CONTRAST: begin
                gamma_c     = SW'(fxc(90, FRAC_BITS));
                denoise_c   = SW'(fxc(12, FRAC_BITS));
                sharpen_c   = SW'(fxc(18, FRAC_BITS));
                shadow_c    = SW'(fxc(7, FRAC_BITS));
                highlight_c = SW'(fxc(10, FRAC_BITS));
                tone_c      = SW'(fxc(48, FRAC_BITS));
                leq_c       = 1'b1;
            end
            PROF_SOFT: begin
                gamma_c     = SW'(fxc(95, FRAC_BITS));
                denoise_c   = SW'(fxc(8, FRAC_BITS));
                sharpen_c   = SW'(fxc(28, FRAC_BITS));
                shadow_c    = SW'(fxc(4, FRAC_BITS));
                highlight_c = SW'(fxc(8, FRAC_BITS));
                tone_c      = SW'(fxc(30, FRAC_BITS));
                leq_c       = 1'b0;
            end
            default: begin
                gamma_c     = SW'(fxc(100, FRAC_BITS));
                denoise_c   = '0;
                sharpen_c   = SW'(fxc(12, FRAC_BITS));
                shadow_c    = '0;
                highlight_c = '0;
                tone_c      = SW'(fxc(25, FRAC_BITS));
                leq_c       = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (contrast_level < CONTRAST_LOW_BAND) begin
            cf_c = SW'(fxc(108, FRAC_BITS));
        end else if (contrast_level > CONTRAST_HIGH_BAND) begin
            cf_c = SW'(fxc(96, FRAC_BITS));
        end else begin
            cf_c = SW'(fxc(102, FRAC_BITS));
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            profile_reg   <= prof;
            gamma_reg     <= gamma_c;
            denoise_reg   <= denoise_c;
            sharpen_reg   <= sharpen_c;
            shadow_reg    <= shadow_c;
            highlight_reg <= highlight_c;
            tone_reg      <= tone_c;
            leq_reg       <= leq_c;
            cf_reg        <= cf_c;
        end
    end

    assign profile         = profile_reg;
    assign prop_gamma      = gamma_reg;
    assign prop_denoise    = denoise_reg;
    assign prop_sharpen    = sharpen_reg;
    assign shadow          = shadow_reg;
    assign highlight       = highlight_reg;
    assign tone            = tone_reg;
    assign local_eq        = leq_reg;
    assign contrast_factor = cf_reg;

endmodule

[rtl/iats_blend.sv]
module iats_blend import iats_pkg::*; #(
    parameter int unsigned FRAC_BITS = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [FRAC_BITS:0]   prop_gain,
    input  logic [FRAC_BITS:0]   prop_gamma,
    input  logic [FRAC_BITS:0]   prop_denoise,
    input  logic [FRAC_BITS:0]   prop_sharpen,
    output logic                 done,
    output logic [FRAC_BITS:0]   avg_gain,
    output logic [FRAC_BITS:0]   avg_gamma,
    output logic [FRAC_BITS:0]   avg_denoise,
    output logic [FRAC_BITS:0]   avg_sharpen
);

    localparam int unsigned SW   = FRAC_BITS + 1;
    // prev*(100-r) + prop*r + 50 stays below 200 * 2^FRAC_BITS
    localparam int unsigned NB   = FRAC_BITS + 8;
    localparam int unsigned K100 = NB + 7;
    localparam int unsigned MW   = NB + 1;
    localparam int unsigned PW   = NB + MW;
    localparam longint unsigned M100 = ((64'd1 << K100) + 64'd99) / 64'd100;
    localparam logic [MW-1:0] M100_W = MW'(M100);

    logic [SW-1:0]   avg_reg [4];
    logic [SW-1:0]   prop_reg [4];
    logic            issue_reg;
    lane_t           lane_reg;
    logic            primed_reg;
    logic            done_reg;

    logic            a_vld_reg;
    lane_t           a_lane_reg;
    logic            a_load_reg;
    logic [SW-1:0]   a_prop_reg;
    logic [NB-1:0]   a_num_reg;

    logic [SW-1:0]     avg_sel, prop_sel;
    logic [RATE_W-1:0] rate;
    logic [NB-1:0]     num_next;
    logic [PW-1:0]     prod;
    logic [SW-1:0]     wb_value;

    assign avg_sel  = avg_reg[lane_reg];
    assign prop_sel = prop_reg[lane_reg];
    assign rate     = blend_rate(lane_reg);
    assign num_next = NB'(avg_sel) * NB'(7'd100 - rate) + NB'(prop_sel) * NB'(rate) + NB'(50);

    // divide by 100 as a multiply by the reciprocal, exact over the numerator range
    assign prod     = PW'(a_num_reg) * PW'(M100_W);
    assign wb_value = a_load_reg ? a_prop_reg : prod[K100 +: SW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg  <= 1'b0;
            lane_reg   <= LANE_GAIN;
            primed_reg <= 1'b0;
            done_reg   <= 1'b0;
            a_vld_reg  <= 1'b0;
            avg_reg[LANE_GAIN]    <= SW'(fxc(100, FRAC_BITS));
            avg_reg[LANE_GAMMA]   <= SW'(fxc(100, FRAC_BITS));
            avg_reg[LANE_DENOISE] <= '0;
            avg_reg[LANE_SHARPEN] <= SW'(fxc(10, FRAC_BITS));
        end else begin
            a_vld_reg <= issue_reg;
            done_reg  <= a_vld_reg && (a_lane_reg == LANE_SHARPEN);
            if (start) begin
                issue_reg <= 1'b1;
                lane_reg  <= LANE_GAIN;
            end else if (issue_reg) begin
                lane_reg <= lane_t'(lane_reg + 2'd1);
                if (lane_reg == LANE_SHARPEN) begin
                    issue_reg <= 1'b0;
                end
            end
            if (a_vld_reg) begin
                avg_reg[a_lane_reg] <= wb_value;
                if (a_lane_reg == LANE_SHARPEN) begin
                    primed_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prop_reg[LANE_GAIN]    <= prop_gain;
            prop_reg[LANE_GAMMA]   <= prop_gamma;
            prop_reg[LANE_DENOISE] <= prop_denoise;
            prop_reg[LANE_SHARPEN] <= prop_sharpen;
        end
        // first frame after reset loads the proposal as is
        a_lane_reg <= lane_reg;
        a_load_reg <= !primed_reg;
        a_prop_reg <= prop_sel;
        a_num_reg  <= num_next;
    end

    assign done        = done_reg;
    assign avg_gain    = avg_reg[LANE_GAIN];
    assign avg_gamma   = avg_reg[LANE_GAMMA];
    assign avg_denoise = avg_reg[LANE_DENOISE];
    assign avg_sharpen = avg_reg[LANE_SHARPEN];

endmodule

[rtl/isp_auto_tune_selector_core.sv]
// the gain divider retires one quotient bit per cycle, then gain scaling runs in ST_MUL and
// ST_QUO and the four smoothing lanes share one unit, one a cycle
// a new request is taken only in ST_IDLE, once the last result has entered the output register
// reset: aresetn low clears control, loads threshold defaults and restores the smoothing
// state to its start values; the next frame after reset loads the proposals directly
module isp_auto_tune_selector_core import iats_pkg::*; #(
    parameter int unsigned FRAC_BITS = 14
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // brightness, contrast_level, noise_level, sharpness_level, zero pad
    input  logic [IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // profile, exposure_gain, gamma_value, denoise_amount, sharpen_level, shadow_boost,
    // highlight_squeeze, tone_weight, local_eq_enable, contrast_factor, zero pad
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned SW  = FRAC_BITS + 1;
    localparam int unsigned QW  = FRAC_BITS + 4;
    // clamped gain times 11 or 9
    localparam int unsigned XW  = FRAC_BITS + 5;
    localparam int unsigned K10 = XW + 4;
    localparam int unsigned MW10 = XW + 1;
    localparam int unsigned PW10 = XW + MW10;
    localparam longint unsigned M10 = ((64'd1 << K10) + 64'd9) / 64'd10;
    localparam logic [MW10-1:0] M10_W = MW10'(M10);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_QUO   = 6'b001000,
        ST_BLEND = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [STAT_W-1:0]  luma_goal_reg, dark_thr_reg, bright_thr_reg;
    logic [STAT_W-1:0]  noise_thr_reg, low_con_thr_reg;
    logic [SHARP_W-1:0] soft_thr_reg;

    logic               accept;
    logic [STAT_W-1:0]  in_bright, in_contrast, in_noise, divisor;
    logic [SHARP_W-1:0] in_sharp;

    profile_t           sel_profile;
    logic [SW-1:0]      sel_gamma, sel_denoise, sel_sharpen, sel_shadow, sel_highlight;
    logic [SW-1:0]      sel_tone, sel_cf;
    logic               sel_leq;

    logic               div_done;
    logic [QW-1:0]      div_q;
    logic [QW-1:0]      gain_lim;
    logic [SW-1:0]      gc_reg;
    logic [XW-1:0]      x_reg;
    logic [3:0]         scale;
    logic [PW10-1:0]    prod10;
    logic [SW-1:0]      y_scaled, prop_gain;

    logic               blend_start, blend_done;
    logic [SW-1:0]      avg_gain, avg_gamma, avg_denoise, avg_sharpen;

    logic               m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic               out_load;

    function automatic logic [SW-1:0] clamp_sw(input logic [SW-1:0] v,
                                               input logic [SW-1:0] lo,
                                               input logic [SW-1:0] hi);
        logic [SW-1:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic [SW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return w[OUT_W-1:0];
    endfunction

    assign in_bright   = s_axis_tdata[15:0];
    assign in_contrast = s_axis_tdata[31:16];
    assign in_noise    = s_axis_tdata[47:32];
    assign in_sharp    = s_axis_tdata[67:48];
    assign divisor     = (in_bright > MIN_DIVISOR) ? in_bright : MIN_DIVISOR;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_goal_reg   <= LUMA_GOAL_RST;
            dark_thr_reg    <= DARK_THR_RST;
            bright_thr_reg  <= BRIGHT_THR_RST;
            noise_thr_reg   <= NOISE_THR_RST;
            low_con_thr_reg <= LOW_CON_THR_RST;
            soft_thr_reg    <= SOFT_THR_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_LUMA_GOAL:   luma_goal_reg   <= cfg_data[STAT_W-1:0];
                CFG_DARK_THR:    dark_thr_reg    <= cfg_data[STAT_W-1:0];
                CFG_BRIGHT_THR:  bright_thr_reg  <= cfg_data[STAT_W-1:0];
                CFG_NOISE_THR:   noise_thr_reg   <= cfg_data[STAT_W-1:0];
                CFG_LOW_CON_THR: low_con_thr_reg <= cfg_data[STAT_W-1:0];
                CFG_SOFT_THR:    soft_thr_reg    <= cfg_data[SHARP_W-1:0];
                default: ;
            endcase
        end
    end

    iats_select #(.FRAC_BITS(FRAC_BITS)) u_select (
        .aclk            (aclk),
        .load            (accept),
        .brightness      (in_bright),
        .contrast_level  (in_contrast),
        .noise_level     (in_noise),
        .sharpness_level (in_sharp),
        .dark_thr        (dark_thr_reg),
        .bright_thr      (bright_thr_reg),
        .noise_thr       (noise_thr_reg),
        .low_con_thr     (low_con_thr_reg),
        .soft_thr        (soft_thr_reg),
        .profile         (sel_profile),
        .prop_gamma      (sel_gamma),
        .prop_denoise    (sel_denoise),
        .prop_sharpen    (sel_sharpen),
        .shadow          (sel_shadow),
        .highlight       (sel_highlight),
        .tone            (sel_tone),
        .local_eq        (sel_leq),
        .contrast_factor (sel_cf)
    );

    iats_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .target   (luma_goal_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // first gain clamp
    always_comb begin
        gain_lim = div_q;
        if (div_q < QW'(fxc(70, FRAC_BITS))) begin
            gain_lim = QW'(fxc(70, FRAC_BITS));
        end else if (div_q > QW'(fxc(155, FRAC_BITS))) begin
            gain_lim = QW'(fxc(155, FRAC_BITS));
        end
    end

    assign scale = (sel_profile == PROF_BRIGHT) ? 4'd9 : 4'd11;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            gc_reg <= SW'(gain_lim);
            x_reg  <= XW'(gain_lim) * XW'(scale);
        end
    end

    // divide by 10 through the reciprocal
    assign prod10   = PW10'(x_reg) * PW10'(M10_W);
    assign y_scaled = prod10[K10 +: SW];

    always_comb begin
        case (sel_profile)
            PROF_LOW_LIGHT: prop_gain = clamp_sw(y_scaled, SW'(fxc(110, FRAC_BITS)),
                                                 SW'(fxc(165, FRAC_BITS)));
            PROF_BRIGHT:    prop_gain = clamp_sw(y_scaled, SW'(fxc(60, FRAC_BITS)),
                                                 SW'(fxc(100, FRAC_BITS)));
            default:        prop_gain = gc_reg;
        endcase
    end

    assign blend_start = (state_reg == ST_QUO);

    iats_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (blend_start),
        .prop_gain    (prop_gain),
        .prop_gamma   (sel_gamma),
        .prop_denoise (sel_denoise),
        .prop_sharpen (sel_sharpen),
        .done         (blend_done),
        .avg_gain     (avg_gain),
        .avg_gamma    (avg_gamma),
        .avg_denoise  (avg_denoise),
        .avg_sharpen  (avg_sharpen)
    );

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_QUO;
            ST_QUO:   state_next = ST_BLEND;
            ST_BLEND: if (blend_done) state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {
                4'b0,
                sat_out(sel_cf),
                sel_leq,
                sat_out(sel_tone),
                sat_out(sel_highlight),
                sat_out(sel_shadow),
                sat_out(clamp_sw(avg_sharpen, '0, SW'(fxc(45, FRAC_BITS)))),
                sat_out(clamp_sw(avg_denoise, '0, SW'(fxc(70, FRAC_BITS)))),
                sat_out(clamp_sw(avg_gamma, SW'(fxc(65, FRAC_BITS)),
                                 SW'(fxc(135, FRAC_BITS)))),
                sat_out(clamp_sw(avg_gain, SW'(fxc(60, FRAC_BITS)),
                                 SW'(fxc(165, FRAC_BITS)))),
                sel_profile
            };
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

[tb/tb_isp_auto_tune_selector_core.sv]
module tb_isp_auto_tune_selector_core;
    import iats_pkg::*;

    localparam int unsigned FRAC_BITS = 14;
    localparam int unsigned PHASES = 7;
    localparam int unsigned FRAMES_PER_PHASE = 250;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 40;

    // register indexes the block must ignore
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_7 = 3'd7;

    // last field in the lowest bits
    typedef struct packed {
        logic [SHARP_W-1:0] sharpness_level;
        logic [STAT_W-1:0]  noise_level;
        logic [STAT_W-1:0]  contrast_level;
        logic [STAT_W-1:0]  brightness;
    } frame_t;

    typedef struct packed {
        logic [OUT_W-1:0] contrast_factor;
        logic             local_eq_enable;
        logic [OUT_W-1:0] tone_weight;
        logic [OUT_W-1:0] highlight_squeeze;
        logic [OUT_W-1:0] shadow_boost;
        logic [OUT_W-1:0] sharpen_level;
        logic [OUT_W-1:0] denoise_amount;
        logic [OUT_W-1:0] gamma_value;
        logic [OUT_W-1:0] exposure_gain;
        profile_t         profile;
    } settings_t;

    class settings_scoreboard;
        logic [STAT_W-1:0]  luma_goal;
        logic [STAT_W-1:0]  dark_thr;
        logic [STAT_W-1:0]  bright_thr;
        logic [STAT_W-1:0]  noise_thr;
        logic [STAT_W-1:0]  low_con_thr;
        logic [SHARP_W-1:0] soft_thr;
        bit                 primed;
        longint unsigned    avg_gain;
        longint unsigned    avg_gamma;
        longint unsigned    avg_denoise;
        longint unsigned    avg_sharpen;
        settings_t          pending_settings[$];
        int unsigned        mismatches;

        function new();
            luma_goal   = LUMA_GOAL_RST;
            dark_thr    = DARK_THR_RST;
            bright_thr  = BRIGHT_THR_RST;
            noise_thr   = NOISE_THR_RST;
            low_con_thr = LOW_CON_THR_RST;
            soft_thr    = SOFT_THR_RST;
            primed      = 1'b0;
            avg_gain    = pct(100);
            avg_gamma   = pct(100);
            avg_denoise = 0;
            avg_sharpen = pct(10);
            mismatches  = 0;
        endfunction

        // p/100 in fixed point, halves up
        function longint unsigned pct(input int unsigned p);
            return ((64'(p) << FRAC_BITS) + 64'd50) / 64'd100;
        endfunction

        function longint unsigned clip(input longint unsigned v, lo, hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint unsigned smooth(input longint unsigned prev, prop, r);
            return (prev * (100 - r) + prop * r + 50) / 100;
        endfunction

        function logic [OUT_W-1:0] sat(input longint unsigned v);
            return (v > OUT_MAX) ? OUT_MAX : v[OUT_W-1:0];
        endfunction

        function int unsigned pending();
            return pending_settings.size();
        endfunction

        function void apply_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_LUMA_GOAL:   luma_goal   = val[STAT_W-1:0];
                CFG_DARK_THR:    dark_thr    = val[STAT_W-1:0];
                CFG_BRIGHT_THR:  bright_thr  = val[STAT_W-1:0];
                CFG_NOISE_THR:   noise_thr   = val[STAT_W-1:0];
                CFG_LOW_CON_THR: low_con_thr = val[STAT_W-1:0];
                CFG_SOFT_THR:    soft_thr    = val[SHARP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_frame(input frame_t f);
            longint unsigned divisor, gain, gamma, denoise, sharpen;
            longint unsigned shadow, highlight, tone, cf;
            logic            leq;
            profile_t        prof;
            settings_t       s;
            divisor = (f.brightness > MIN_DIVISOR) ? f.brightness : MIN_DIVISOR;
            gain = (64'(luma_goal) << FRAC_BITS) / divisor;
            gain = clip(gain, pct(70), pct(155));
            gamma = pct(100); denoise = 0; sharpen = pct(12);
            shadow = 0; highlight = 0; tone = pct(25); leq = 1'b0;
            prof = PROF_NORMAL;
            // first matching test wins
            if (f.brightness < dark_thr) begin
                prof = PROF_LOW_LIGHT;
                gain = clip(gain * 110 / 100, pct(110), pct(165));
                gamma = pct(72); denoise = pct(45); sharpen = pct(12);
                shadow = pct(20); highlight = pct(12); tone = pct(45); leq = 1'b1;
            end else if (f.brightness > bright_thr) begin
                prof = PROF_BRIGHT;
                gain = clip(gain * 90 / 100, pct(60), pct(100));
                gamma = pct(118); denoise = pct(5); sharpen = pct(8);
                shadow = pct(2); highlight = pct(32); tone = pct(42);
            end else if (f.noise_level > noise_thr) begin
                prof = PROF_HIGH_NOISE;
                gamma = pct(82); denoise = pct(38); sharpen = pct(14);
                shadow = pct(8); highlight = pct(15); tone = pct(34);
            end else if (f.contrast_level < low_con_thr) begin
                prof = PROF_LOW_CONTRAST;
                gamma = pct(90); denoise = pct(12); sharpen = pct(18);
                shadow = pct(7); highlight = pct(10); tone = pct(48); leq = 1'b1;
            end else if (f.sharpness_level < soft_thr) begin
                prof = PROF_SOFT;
                gamma = pct(95); denoise = pct(8); sharpen = pct(28);
                shadow = pct(4); highlight = pct(8); tone = pct(30);
            end

            if (!primed) begin
                avg_gain = gain; avg_gamma = gamma;
                avg_denoise = denoise; avg_sharpen = sharpen;
                primed = 1'b1;
            end else begin
                avg_gain    = smooth(avg_gain, gain, 18);
                avg_gamma   = smooth(avg_gamma, gamma, 16);
                avg_denoise = smooth(avg_denoise, denoise, 22);
                avg_sharpen = smooth(avg_sharpen, sharpen, 22);
            end

            if (f.contrast_level < CONTRAST_LOW_BAND) cf = pct(108);
            else if (f.contrast_level > CONTRAST_HIGH_BAND) cf = pct(96);
            else cf = pct(102);

            s.profile           = prof;
            s.exposure_gain     = sat(clip(avg_gain, pct(60), pct(165)));
            s.gamma_value       = sat(clip(avg_gamma, pct(65), pct(135)));
            s.denoise_amount    = sat(clip(avg_denoise, 0, pct(70)));
            s.sharpen_level     = sat(clip(avg_sharpen, 0, pct(45)));
            s.shadow_boost      = sat(shadow);
            s.highlight_squeeze = sat(highlight);
            s.tone_weight       = sat(tone);
            s.local_eq_enable   = leq;
            s.contrast_factor   = sat(cf);
            pending_settings.push_back(s);
        endfunction

        function void match(input string field, input longint unsigned want, got);
            if (want != got) begin
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_settings(input logic [OUT_TDATA_W-1:0] word);
            settings_t got, want;
            got = settings_t'(word[$bits(settings_t)-1:0]);
            if (pending_settings.size() == 0) begin
                $display("%0t: result with no request pending, expected none got %h",
                         $time, word);
                mismatches++;
                return;
            end
            want = pending_settings.pop_front();
            match("profile", want.profile, got.profile);
            match("exposure_gain", want.exposure_gain, got.exposure_gain);
            match("gamma_value", want.gamma_value, got.gamma_value);
            match("denoise_amount", want.denoise_amount, got.denoise_amount);
            match("sharpen_level", want.sharpen_level, got.sharpen_level);
            match("shadow_boost", want.shadow_boost, got.shadow_boost);
            match("highlight_squeeze", want.highlight_squeeze, got.highlight_squeeze);
            match("tone_weight", want.tone_weight, got.tone_weight);
            match("local_eq_enable", want.local_eq_enable, got.local_eq_enable);
            match("contrast_factor", want.contrast_factor, got.contrast_factor);
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    bit                     steady = 1'b0;
    int unsigned            quiet_cycles = 0;
    settings_scoreboard     settings_sb;

    isp_auto_tune_selector_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 9);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            settings_sb.check_settings(m_axis_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // caller drops cfg_valid after the last write of a batch
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_addr  <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        settings_sb.apply_reg(idx, val);
    endtask

    task automatic send_frame(input frame_t f);
        if (!steady && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
        s_axis_tdata  <= {{(IN_TDATA_W - $bits(frame_t)){1'b0}}, f};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        settings_sb.note_frame(f);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (settings_sb.pending() != 0);
    endtask

    task automatic program_phase(input int unsigned p);
        logic [CFG_ADDR_W-1:0] regs[6];
        regs = '{CFG_LUMA_GOAL, CFG_DARK_THR, CFG_BRIGHT_THR,
                 CFG_NOISE_THR, CFG_LOW_CON_THR, CFG_SOFT_THR};
        case (p)
            1: begin
                foreach (regs[i]) write_reg(regs[i], '0);
                write_reg(CFG_SPARE_6, CFG_DATA_W'($urandom));
            end
            2: begin
                // upper bits of the 16-bit registers are dropped
                foreach (regs[i]) write_reg(regs[i], '1);
                write_reg(CFG_SPARE_7, CFG_DATA_W'($urandom));
            end
            3: begin
                write_reg(CFG_LUMA_GOAL, CFG_DATA_W'(LUMA_GOAL_RST));
                write_reg(CFG_DARK_THR, CFG_DATA_W'(DARK_THR_RST));
                write_reg(CFG_BRIGHT_THR, CFG_DATA_W'(BRIGHT_THR_RST));
                write_reg(CFG_NOISE_THR, CFG_DATA_W'(NOISE_THR_RST));
                write_reg(CFG_LOW_CON_THR, CFG_DATA_W'(LOW_CON_THR_RST));
                write_reg(CFG_SOFT_THR, SOFT_THR_RST);
            end
            4, 5: begin
                write_reg(CFG_LUMA_GOAL, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(CFG_DARK_THR, CFG_DATA_W'($urandom_range(0, 30000)));
                write_reg(CFG_BRIGHT_THR, CFG_DATA_W'($urandom_range(30000, 65535)));
                write_reg(CFG_NOISE_THR, CFG_DATA_W'($urandom_range(0, 8000)));
                write_reg(CFG_LOW_CON_THR, CFG_DATA_W'($urandom_range(0, 30000)));
                write_reg(CFG_SOFT_THR, CFG_DATA_W'($urandom_range(0, 5000)));
            end
            default: begin
                foreach (regs[i]) write_reg(regs[i], CFG_DATA_W'($urandom));
                write_reg(CFG_SPARE_6, CFG_DATA_W'($urandom));
                write_reg(CFG_SPARE_7, CFG_DATA_W'($urandom));
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    // values near a threshold, below and above it, plus edges and full-range noise
    function automatic logic [SHARP_W-1:0] pick_near(input longint unsigned thr,
                                                     input int unsigned w);
        longint unsigned top;
        longint          v;
        top = (64'd1 << w) - 1;
        if (thr > top) thr = top;
        case ($urandom_range(0, 9))
            0, 1, 2: v = longint'(thr) + int'($urandom_range(0, 8)) - 4;
            3:       v = (thr == 0) ? 0 : $urandom_range(0, 32'(thr - 1));
            4:       v = (thr >= top) ? top : $urandom_range(32'(thr + 1), 32'(top));
            5:       v = 0;
            6:       v = top;
            default: v = $urandom & top;
        endcase
        if (v < 0) v = 0;
        if (v > longint'(top)) v = top;
        return v[SHARP_W-1:0];
    endfunction

    function automatic frame_t random_frame();
        frame_t          f;
        longint unsigned b_thr, c_thr;
        case ($urandom_range(0, 2))
            0:       b_thr = settings_sb.dark_thr;
            1:       b_thr = settings_sb.bright_thr;
            default: b_thr = MIN_DIVISOR;
        endcase
        case ($urandom_range(0, 2))
            0:       c_thr = settings_sb.low_con_thr;
            1:       c_thr = CONTRAST_LOW_BAND;
            default: c_thr = CONTRAST_HIGH_BAND;
        endcase
        f.brightness      = STAT_W'(pick_near(b_thr, STAT_W));
        f.contrast_level  = STAT_W'(pick_near(c_thr, STAT_W));
        f.noise_level     = STAT_W'(pick_near(settings_sb.noise_thr, STAT_W));
        f.sharpness_level = pick_near(settings_sb.soft_thr, SHARP_W);
        return f;
    endfunction

    function automatic frame_t mk(input logic [STAT_W-1:0] b, c, n,
                                  input logic [SHARP_W-1:0] s);
        frame_t f;
        f.brightness = b; f.contrast_level = c; f.noise_level = n; f.sharpness_level = s;
        return f;
    endfunction

    initial begin
        frame_t directed[$];
        settings_sb = new();
        // boundaries of every profile test, the divisor floor and the contrast bands
        directed = '{
            mk(16'd0, 16'd0, 16'd0, 20'd0),
            mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF),
            mk(16'd5119, 16'd20000, 16'd0, 20'd1000),
            mk(16'd5120, 16'd20000, 16'd0, 20'd1000),
            mk(16'd5121, 16'd20000, 16'd0, 20'd1000),
            mk(16'd14079, 16'd20000, 16'd0, 20'd1000),
            mk(16'd14080, 16'd20000, 16'd0, 20'd1000),
            mk(16'd42240, 16'd20000, 16'd0, 20'd1000),
            mk(16'd42241, 16'd20000, 16'd0, 20'd1000),
            mk(16'd30000, 16'd20000, 16'd2048, 20'd1000),
            mk(16'd30000, 16'd20000, 16'd2049, 20'd1000),
            mk(16'd30000, 16'd10751, 16'd0, 20'd1000),
            mk(16'd30000, 16'd10752, 16'd0, 20'd1000),
            mk(16'd30000, 16'd11519, 16'd0, 20'd1000),
            mk(16'd30000, 16'd11520, 16'd0, 20'd1000),
            mk(16'd30000, 16'd24320, 16'd0, 20'd1000),
            mk(16'd30000, 16'd24321, 16'd0, 20'd1000),
            mk(16'd30000, 16'd20000, 16'd0, 20'd699),
            mk(16'd30000, 16'd20000, 16'd0, 20'd700),
            mk(16'd30000, 16'd20000, 16'd0, 20'd0),
            mk(16'd30000, 16'd20000, 16'hFFFF, 20'd1000),
            mk(16'd20000, 16'd0, 16'd0, 20'hFFFFF),
            mk(16'd40000, 16'hFFFF, 16'd0, 20'd0)
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int unsigned p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                program_phase(p);
            end
            steady <= (p == 3);
            for (int unsigned n = 0; n < FRAMES_PER_PHASE; n++) begin
                // hold off mid-phase until the pipeline is empty
                if (p == 5 && n == FRAMES_PER_PHASE / 2) begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                if (p == 0 && n < directed.size()) send_frame(directed[n]);
                else send_frame(random_frame());
            end
        end
        s_axis_tvalid <= 1'b0;
        steady <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (settings_sb.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, settings_sb.pending());
        end
        if (settings_sb.mismatches == 0 && settings_sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/iats_pkg.sv
rtl/iats_div.sv
rtl/iats_select.sv
rtl/iats_blend.sv
rtl/isp_auto_tune_selector_core.sv
tb/tb_isp_auto_tune_selector_core.sv
